FILE: rtl/core/sha512_pkg.sv
// SHA-512 stream hasher: shared types, constants and round functions.
// No dependencies.
`default_nettype none
package sha512_pkg;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned QDepth = 4;

  // front-to-back command
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } eng_state_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD,
    PH_LEN,
    PH_DONE
  } pad_phase_t;

  function automatic logic [63:0] iv_word(input logic [2:0] i);
    case (i)
      3'd0: iv_word = 64'h6a09e667f3bcc908;
      3'd1: iv_word = 64'hbb67ae8584caa73b;
      3'd2: iv_word = 64'h3c6ef372fe94f82b;
      3'd3: iv_word = 64'ha54ff53a5f1d36f1;
      3'd4: iv_word = 64'h510e527fade682d1;
      3'd5: iv_word = 64'h9b05688c2b3e6c1f;
      3'd6: iv_word = 64'h1f83d9abfb41bd6b;
      default: iv_word = 64'h5be0cd19137e2179;
    endcase
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] i);
    case (i)
      7'd0: round_k = 64'h428a2f98d728ae22; 7'd1: round_k = 64'h7137449123ef65cd;
      7'd2: round_k = 64'hb5c0fbcfec4d3b2f; 7'd3: round_k = 64'he9b5dba58189dbbc;
      7'd4: round_k = 64'h3956c25bf348b538; 7'd5: round_k = 64'h59f111f1b605d019;
      7'd6: round_k = 64'h923f82a4af194f9b; 7'd7: round_k = 64'hab1c5ed5da6d8118;
      7'd8: round_k = 64'hd807aa98a3030242; 7'd9: round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec; 7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = 64'h0;
    endcase
  endfunction

  function automatic logic [63:0] ror64(input logic [63:0] v, input int unsigned n);
    ror64 = (v >> n) | (v << (64 - n));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha512_cmd_fifo.sv
// Short command queue between the front end and the hashing engine.
// Depends on sha512_pkg.
`default_nettype none
module sha512_cmd_fifo
  import sha512_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  wire  rd_en,
  output cmd_t rd_cmd,
  output logic empty
);
  localparam int unsigned AW = $clog2(QDepth);

  cmd_t slots [QDepth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;

  assign full   = (count == (AW+1)'(QDepth));
  assign empty  = (count == '0);
  assign rd_cmd = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en && !full) slots[wr_ptr] <= wr_cmd;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !full) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en && !empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/sha512_engine.sv
// Back end: block gathering, padding, 80-round compression and digest output.
// Depends on sha512_pkg.
`default_nettype none
module sha512_engine
  import sha512_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  cmd_t         cmd,
  input  wire          cmd_empty,
  output logic         cmd_take,
  output logic [63:0]  digest_word,
  output logic [2:0]   word_index,
  output logic         last_word,
  output logic         empty,
  input  wire          pop
);
  eng_state_t state, state_next;
  pad_phase_t phase;           // padding progress of a closing message
  logic [63:0] w [16];         // message schedule window, also the block buffer
  logic [63:0] h [8];
  logic [63:0] v [8];
  logic [6:0]  fill_count;
  logic [127:0] bits;
  logic [6:0]  rnd;
  logic [2:0]  emit_idx;
  logic        closing;        // a message end is being processed

  // schedule and round arithmetic
  logic [63:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2;
  always_comb begin
    s0    = ror64(w[1], 1) ^ ror64(w[1], 8) ^ (w[1] >> 7);
    s1    = ror64(w[14], 19) ^ ror64(w[14], 61) ^ (w[14] >> 6);
    w_new = s1 + w[9] + s0 + w[0];
    big1  = ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1    = v[7] + big1 + ch + round_k(rnd) + w[0];
    big0  = ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2    = big0 + maj;
  end

  assign digest_word = h[emit_idx];
  assign word_index  = emit_idx;
  assign last_word   = (emit_idx == 3'd7);
  assign empty       = (state != ST_EMIT);
  assign cmd_take    = (state == ST_IDLE) && !closing && !cmd_empty;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (closing && phase == PH_DONE) state_next = ST_EMIT;
        else if (closing && fill_count == 7'd0 && phase != PH_DATA) state_next = ST_ROUND;
        else if (!closing && !cmd_empty && cmd.valid && fill_count == 7'd127)
          state_next = ST_ROUND;
      end
      ST_ROUND:  if (rnd == 7'(NumRounds - 1)) state_next = ST_FOLD;
      ST_FOLD:   state_next = ST_IDLE;
      ST_EMIT:   if (pop && emit_idx == 3'd7) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      bits       <= '0;
      rnd        <= '0;
      emit_idx   <= '0;
      closing    <= 1'b0;
      phase      <= PH_DATA;
      for (int i = 0; i < 8; i++) h[i] <= iv_word(3'(i));
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            if (cmd.valid) begin
              w[fill_count[6:3]][(7 - fill_count[2:0]) * 8 +: 8] <= cmd.data;
              fill_count <= fill_count + 1'b1;
              bits <= bits + 128'd8;
            end
            if (cmd.last) begin
              closing <= 1'b1;
              phase   <= PH_DATA;
            end
            if (cmd.valid && fill_count == 7'd127) begin
              rnd <= '0;
              for (int i = 0; i < 8; i++) v[i] <= h[i];
            end
          end else if (closing) begin
            // padding: one byte per cycle, held while a full block is compressed, then the length
            case (phase)
              PH_DATA: begin
                w[fill_count[6:3]][(7 - fill_count[2:0]) * 8 +: 8] <= 8'h80;
                fill_count <= fill_count + 1'b1;
                phase <= PH_PAD;
              end
              PH_PAD: begin
                if (fill_count == 7'd0) begin
                  // block ran out before the length field: compress it
                  rnd <= '0;
                  for (int i = 0; i < 8; i++) v[i] <= h[i];
                end else if (fill_count == 7'd112) begin
                  w[14] <= bits[127:64];
                  w[15] <= bits[63:0];
                  fill_count <= '0;
                  phase <= PH_LEN;
                end else begin
                  w[fill_count[6:3]][(7 - fill_count[2:0]) * 8 +: 8] <= 8'h00;
                  fill_count <= fill_count + 1'b1;
                end
              end
              PH_LEN: begin
                rnd <= '0;
                for (int i = 0; i < 8; i++) v[i] <= h[i];
              end
              default: begin
                emit_idx <= '0;
              end
            endcase
          end
        end
        ST_ROUND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          rnd <= rnd + 1'b1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          if (closing && phase == PH_LEN) phase <= PH_DONE;
          // extra padding block: its first zero byte goes in here
          if (closing && phase == PH_PAD) begin
            w[0][63:56] <= 8'h00;
            fill_count  <= 7'd1;
          end
        end
        ST_EMIT: begin
          if (pop) begin
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == 3'd7) begin
              closing    <= 1'b0;
              phase      <= PH_DATA;
              fill_count <= '0;
              bits       <= '0;
              for (int i = 0; i < 8; i++) h[i] <= iv_word(3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/sha512_stream_hasher.sv
// SHA-512 stream hasher: byte queue front end and compression back end.
// Flow: a byte passes the 4-entry queue and is stored in the block buffer; the 128th byte
// of a block starts the 80 rounds and the fold, and input stalls once the queue fills.
// A message end adds padding (one byte at a time, then the length and the launch),
// one or two compressions, the start of output, then 8 words, one per pop.
// Reset: synchronous rst restores the initial hash values and clears counts and queue.
`default_nettype none
module sha512_stream_hasher
  import sha512_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire  [7:0]  msg_byte,
  input  wire         byte_valid,
  input  wire         end_of_msg,
  input  wire         push,
  output logic        full,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        empty,
  input  wire         pop
);
  cmd_t in_cmd, q_cmd;
  logic q_empty, q_take, q_full;

  // idle items carry nothing: dropped at the front
  assign in_cmd = '{data: msg_byte, valid: byte_valid, last: end_of_msg};
  assign full = q_full;

  sha512_cmd_fifo u_fifo (
    .clk(clk), .rst(rst),
    .wr_en(push && (byte_valid || end_of_msg)), .wr_cmd(in_cmd), .full(q_full),
    .rd_en(q_take), .rd_cmd(q_cmd), .empty(q_empty)
  );

  sha512_engine u_eng (
    .clk(clk), .rst(rst), .cmd(q_cmd), .cmd_empty(q_empty), .cmd_take(q_take),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
    .empty(empty), .pop(pop)
  );

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_word == (word_index == 3'd7))) else $error("last_word mismatch");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_word) |=> (!empty && word_index == $past(word_index) + 3'd1))
    else $error("digest index skipped");
  a_first: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> word_index == 3'd0) else $error("digest not starting at word 0");
endmodule
`default_nettype wire
